[sv/dhme_pkg.sv]
// Package for the Diffie-Hellman modular exponentiation block.
// Holds configuration register indexes, command codes and the sequencer state type.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package dhme_pkg;

    localparam int CFG_IDX_W = 1;
    localparam int FIELD_W   = 32;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MODULUS   = 1'b0,
        CFG_GENERATOR = 1'b1
    } t_cfg_idx;

    typedef enum logic {
        CMD_PUBLIC = 1'b0,
        CMD_SHARED = 1'b1
    } t_cmd;

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_RED  = 5'b00010,
        S_SQR  = 5'b00100,
        S_MUL  = 5'b01000,
        S_DONE = 5'b10000
    } t_state;

    typedef struct packed {
        logic start;
        logic busy;
        logic done;
    } t_mm_ctl;

endpackage

`default_nettype wire

[sv/dhme_in_if.sv]
// Request channel interface: command, exponent and peer value.
// Depends on dhme_pkg.
`timescale 1ns / 1ps
`default_nettype none

interface dhme_in_if;
    logic                           valid;
    logic                           ready;
    logic                           command;
    logic [dhme_pkg::FIELD_W-1:0]   exponent;
    logic [dhme_pkg::FIELD_W-1:0]   peer_value;

    modport source (output valid, command, exponent, peer_value, input ready);
    modport sink   (input valid, command, exponent, peer_value, output ready);
endinterface

`default_nettype wire

[sv/dhme_out_if.sv]
// Result channel interface: key value.
// Depends on dhme_pkg.
`timescale 1ns / 1ps
`default_nettype none

interface dhme_out_if;
    logic                           valid;
    logic                           ready;
    logic [dhme_pkg::FIELD_W-1:0]   key_value;

    modport source (output valid, key_value, input ready);
    modport sink   (input valid, key_value, output ready);
endinterface

`default_nettype wire

[sv/dhme_cfg_if.sv]
// Configuration write channel interface: register index and write data.
// Depends on dhme_pkg.
`timescale 1ns / 1ps
`default_nettype none

interface dhme_cfg_if;
    logic                               valid;
    logic                               ready;
    logic [dhme_pkg::CFG_IDX_W-1:0]     reg_index;
    logic [dhme_pkg::FIELD_W-1:0]       data;

    modport source (output valid, reg_index, data, input ready);
    modport sink   (input valid, reg_index, data, output ready);
endinterface

`default_nettype wire

[sv/dhme_modmul.sv]
// Bit-serial modular multiplier: (a * b) mod m, one multiplier bit per cycle.
// Depends on dhme_pkg for the control struct.
`timescale 1ns / 1ps
`default_nettype none

module dhme_modmul #(
    parameter int WIDTH = 32
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire dhme_pkg::t_mm_ctl      i_ctl,
    input  wire logic [WIDTH-1:0]       i_a,
    input  wire logic [WIDTH-1:0]       i_b,
    input  wire logic [WIDTH-1:0]       i_m,
    output dhme_pkg::t_mm_ctl           o_ctl,
    output logic [WIDTH-1:0]            o_result
);

    localparam int CNT_W = $clog2(WIDTH + 1);

    logic [WIDTH-1:0]   r_acc, r_a, r_b, r_m;
    logic [CNT_W-1:0]   r_cnt;
    logic               r_busy, r_done;

    logic [WIDTH+1:0]   w_t, w_m1, w_m2;
    logic [WIDTH-1:0]   n_acc;

    always_comb begin
        w_m1 = (WIDTH+2)'(r_m);
        w_m2 = {1'b0, r_m, 1'b0};
        w_t  = {1'b0, r_acc, 1'b0} + (r_b[WIDTH-1] ? (WIDTH+2)'(r_a) : '0);
        if (w_t >= w_m2) begin
            n_acc = WIDTH'(w_t - w_m2);
        end else if (w_t >= w_m1) begin
            n_acc = WIDTH'(w_t - w_m1);
        end else begin
            n_acc = WIDTH'(w_t);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_ctl.start && !r_busy) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(WIDTH);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.start && !r_busy) begin
            r_acc <= '0;
            r_a   <= i_a;
            r_b   <= i_b;
            r_m   <= i_m;
        end else if (r_busy) begin
            r_acc <= n_acc;
            r_b   <= {r_b[WIDTH-2:0], 1'b0};
        end
    end

    assign o_ctl.start = 1'b0;
    assign o_ctl.busy  = r_busy;
    assign o_ctl.done  = r_done;
    assign o_result    = r_acc;

endmodule

`default_nettype wire

[sv/dh_modular_exponentiation.sv]
// Diffie-Hellman modular exponentiation: top level with sequencer and registers.
// Depends on dhme_pkg, dhme_in_if, dhme_out_if, dhme_cfg_if and dhme_modmul.
//
// Computes base^exponent mod modulus by square-and-multiply over the exponent bits, MSB
// first; the base is the generator register (public-key command) or the peer value
// (shared-key command). All arithmetic runs on one bit-serial modular multiplier: it
// reduces the base once, then squares for every exponent bit and multiplies for every
// set bit. A modulus below two returns 0 without using the multiplier. The request
// channel is ready only between requests; a finished result waits in an output
// register. Config writes are taken in any cycle and must only be issued while no
// request is in progress.
`timescale 1ns / 1ps
`default_nettype none

module dh_modular_exponentiation #(
    parameter int WIDTH = 32
) (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    dhme_in_if.sink     i_in,
    dhme_cfg_if.sink    i_cfg,
    dhme_out_if.source  o_out
);

    localparam int CNT_W = $clog2(WIDTH + 1);

    dhme_pkg::t_state   r_state;
    logic [WIDTH-1:0]   r_modulus, r_generator;
    logic [WIDTH-1:0]   r_base, r_exp, r_res;
    logic [CNT_W-1:0]   r_bit_cnt;
    logic               r_mm_start;
    logic               r_out_valid;
    logic [dhme_pkg::FIELD_W-1:0] r_key;

    dhme_pkg::t_mm_ctl  w_mm_req, w_mm_sts;
    logic [WIDTH-1:0]   w_mm_a, w_mm_b, w_mm_res;
    logic               w_in_acc, w_last_bit;

    assign w_in_acc   = i_in.valid && i_in.ready;
    assign i_in.ready = (r_state == dhme_pkg::S_IDLE);
    assign i_cfg.ready = 1'b1;
    assign w_last_bit = (r_bit_cnt == CNT_W'(1));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_modulus   <= WIDTH'(32'd4294967291);
            r_generator <= WIDTH'(32'd2);
        end else if (i_cfg.valid) begin
            case (dhme_pkg::t_cfg_idx'(i_cfg.reg_index))
                dhme_pkg::CFG_MODULUS:   r_modulus   <= WIDTH'(i_cfg.data);
                dhme_pkg::CFG_GENERATOR: r_generator <= WIDTH'(i_cfg.data);
                default: ;
            endcase
        end
    end

    always_comb begin
        case (r_state)
            dhme_pkg::S_RED: begin
                w_mm_a = WIDTH'(1);
                w_mm_b = r_base;
            end
            dhme_pkg::S_MUL: begin
                w_mm_a = r_res;
                w_mm_b = r_base;
            end
            default: begin
                w_mm_a = r_res;
                w_mm_b = r_res;
            end
        endcase
    end

    assign w_mm_req.start = r_mm_start;
    assign w_mm_req.busy  = 1'b0;
    assign w_mm_req.done  = 1'b0;

    dhme_modmul #(
        .WIDTH (WIDTH)
    ) u_modmul (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctl    (w_mm_req),
        .i_a      (w_mm_a),
        .i_b      (w_mm_b),
        .i_m      (r_modulus),
        .o_ctl    (w_mm_sts),
        .o_result (w_mm_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= dhme_pkg::S_IDLE;
            r_mm_start  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_mm_start <= 1'b0;
            if (o_out.valid && o_out.ready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                dhme_pkg::S_IDLE: begin
                    if (w_in_acc) begin
                        if (r_modulus < WIDTH'(2)) begin
                            r_state <= dhme_pkg::S_DONE;
                        end else begin
                            r_state    <= dhme_pkg::S_RED;
                            r_mm_start <= 1'b1;
                        end
                    end
                end
                dhme_pkg::S_RED: begin
                    if (w_mm_sts.done) begin
                        r_state    <= dhme_pkg::S_SQR;
                        r_mm_start <= 1'b1;
                    end
                end
                dhme_pkg::S_SQR: begin
                    if (w_mm_sts.done) begin
                        if (r_exp[WIDTH-1]) begin
                            r_state    <= dhme_pkg::S_MUL;
                            r_mm_start <= 1'b1;
                        end else if (w_last_bit) begin
                            r_state <= dhme_pkg::S_DONE;
                        end else begin
                            r_mm_start <= 1'b1;
                        end
                    end
                end
                dhme_pkg::S_MUL: begin
                    if (w_mm_sts.done) begin
                        if (w_last_bit) begin
                            r_state <= dhme_pkg::S_DONE;
                        end else begin
                            r_state    <= dhme_pkg::S_SQR;
                            r_mm_start <= 1'b1;
                        end
                    end
                end
                dhme_pkg::S_DONE: begin
                    if (!r_out_valid || o_out.ready) begin
                        r_out_valid <= 1'b1;
                        r_state     <= dhme_pkg::S_IDLE;
                    end
                end
                default: begin
                    r_state <= dhme_pkg::S_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            dhme_pkg::S_IDLE: begin
                if (w_in_acc) begin
                    r_base    <= (i_in.command == dhme_pkg::CMD_SHARED) ?
                                 WIDTH'(i_in.peer_value) : r_generator;
                    r_exp     <= WIDTH'(i_in.exponent);
                    r_bit_cnt <= CNT_W'(WIDTH);
                    r_res     <= (r_modulus < WIDTH'(2)) ? '0 : WIDTH'(1);
                end
            end
            dhme_pkg::S_RED: begin
                if (w_mm_sts.done) begin
                    r_base <= w_mm_res;
                end
            end
            dhme_pkg::S_SQR: begin
                if (w_mm_sts.done) begin
                    r_res <= w_mm_res;
                    if (!r_exp[WIDTH-1]) begin
                        r_exp     <= {r_exp[WIDTH-2:0], 1'b0};
                        r_bit_cnt <= r_bit_cnt - 1'b1;
                    end
                end
            end
            dhme_pkg::S_MUL: begin
                if (w_mm_sts.done) begin
                    r_res     <= w_mm_res;
                    r_exp     <= {r_exp[WIDTH-2:0], 1'b0};
                    r_bit_cnt <= r_bit_cnt - 1'b1;
                end
            end
            dhme_pkg::S_DONE: begin
                if (!r_out_valid || o_out.ready) begin
                    r_key <= dhme_pkg::FIELD_W'(r_res);
                end
            end
            default: ;
        endcase
    end

    assign o_out.valid     = r_out_valid;
    assign o_out.key_value = r_key;

    a_accept_leaves_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_acc |=> (r_state != dhme_pkg::S_IDLE))
        else $error("request accepted but sequencer stayed idle");

    a_done_only_when_working: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_mm_sts.done |-> (r_state == dhme_pkg::S_RED || r_state == dhme_pkg::S_SQR ||
                           r_state == dhme_pkg::S_MUL))
        else $error("multiplier finished outside a working state");

    a_no_start_while_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_mm_start |-> !w_mm_sts.busy)
        else $error("multiplier started while busy");

    a_result_reduced: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == dhme_pkg::S_DONE && r_modulus >= WIDTH'(2)) |-> (r_res < r_modulus))
        else $error("result not reduced below modulus");

endmodule

`default_nettype wire
